// File: hdl/vvbs_pkg.sv
package vvbs_pkg;

    // Reset value of the inverse mass register (12.5 in Q8.16).
    localparam logic [23:0] INV_MASS_RESET = 24'd819200;
    localparam logic signed [17:0] FWD_ONE = 18'sd65536;

    // Command codes.
    localparam logic [1:0] CMD_STEP     = 2'd0;
    localparam logic [1:0] CMD_LOAD_POS = 2'd1;
    localparam logic [1:0] CMD_LOAD_VEL = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HALF1,
        ST_POS,
        ST_ACC,
        ST_HALF2,
        ST_SQSUM,
        ST_SQRT,
        ST_SQRT_RND,
        ST_DIV,
        ST_DIV_NEXT,
        ST_OUT
    } state_t;

    // Saturate a signed 66 bit value to 32 bits.
    function automatic logic [31:0] sat32(input logic signed [65:0] x);
        logic [31:0] r;
        if (x > 66'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (x < -66'sd2147483648)
            r = 32'h8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

// File: hdl/velocity_verlet_body_step_core.sv
// Velocity-Verlet point mass integrator. Each item (step, load or unused
// command) yields one result. A step runs through a small sequencer that uses
// one multiply unit for the twelve products, then computes the squared speed
// and a bit-serial square root with a rounding step, and, when the velocity
// is nonzero, runs three serial divisions for the forward vector before it
// posts the result. The block is not ready while an item is in work; the
// result is driven from the state registers and the next item is accepted
// in the cycle after the result transfer.
module velocity_verlet_body_step_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [23:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[1:0], dt[17:2], vec_x[49:18], vec_y[81:50], vec_z[113:82], zero pad
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x..z[95:0], vel_x..z[191:96], speed[222:192], fwd_x..z[276:223], pad
    output logic [279:0] m_axis_tdata
);

    vvbs_pkg::state_t state_reg, state_next;

    logic [23:0]        inv_mass_reg;
    logic [1:0]         cmd_reg;
    logic [15:0]        dt_reg;
    logic [31:0]        vec_reg [3];
    logic [31:0]        pos_reg [3];
    logic [31:0]        vel_reg [3];
    logic [31:0]        acc_reg [3];
    logic [17:0]        fwd_reg [3];
    logic [1:0]         idx_reg;
    logic               ph_reg;
    logic [65:0]        sq_reg;
    logic [65:0]        rem_reg;
    logic [33:0]        root_reg;
    logic [5:0]         cnt_reg;
    logic [49:0]        dnum_reg;
    logic [49:0]        drem_reg;
    logic [49:0]        quo_reg;
    logic               out_valid_reg;
    logic               busy;

    logic signed [31:0] mac_a;
    logic signed [24:0] mac_b;
    logic        [4:0]  mac_sh;
    logic signed [31:0] mac_acc;
    logic        [31:0] mac_res;

    vvbs_mac u_mac
    (
        .clk    (clk),
        .op_a   (mac_a),
        .op_b   (mac_b),
        .shift  (mac_sh),
        .acc    (mac_acc),
        .result (mac_res)
    );

    assign busy          = (state_reg != vvbs_pkg::ST_IDLE) || out_valid_reg;
    assign s_axis_tready = !busy;
    assign m_axis_tvalid = out_valid_reg;

    // Multiplier operand select.
    always_comb
    begin
        mac_a   = 32'sd0;
        mac_b   = 25'sd0;
        mac_sh  = 5'd16;
        mac_acc = 32'sd0;
        case (state_reg)
            vvbs_pkg::ST_HALF1, vvbs_pkg::ST_HALF2:
            begin
                mac_a   = acc_reg[idx_reg];
                mac_b   = {9'd0, dt_reg};
                mac_sh  = 5'd17;
                mac_acc = vel_reg[idx_reg];
            end
            vvbs_pkg::ST_POS:
            begin
                mac_a   = vel_reg[idx_reg];
                mac_b   = {9'd0, dt_reg};
                mac_acc = pos_reg[idx_reg];
            end
            vvbs_pkg::ST_ACC:
            begin
                mac_a = vec_reg[idx_reg];
                mac_b = {1'b0, inv_mass_reg};
            end
            default:
            begin
                mac_a = 32'sd0;
            end
        endcase
    end

    // Square root step and division step values.
    logic [65:0] sqrt_trial;
    logic        sqrt_ok;
    logic [49:0] div_trial;
    logic [32:0] len33;
    logic [31:0] vabs;
    logic [49:0] dsh;
    always_comb
    begin
        sqrt_trial = {rem_reg[63:0], sq_reg[63:62]};
        sqrt_ok    = sqrt_trial >= {30'd0, root_reg, 2'b01};
        len33      = root_reg[32:0];
        dsh        = {drem_reg[48:0], dnum_reg[49]};
        div_trial  = dsh - {17'd0, len33};
        vabs       = vel_reg[idx_reg][31] ? 32'(-vel_reg[idx_reg]) : vel_reg[idx_reg];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vvbs_pkg::ST_IDLE:
                if (s_axis_tvalid && !busy)
                    state_next = (s_axis_tdata[1:0] == vvbs_pkg::CMD_STEP)
                        ? vvbs_pkg::ST_HALF1 : vvbs_pkg::ST_SQSUM;
            vvbs_pkg::ST_HALF1:
                if (ph_reg && idx_reg == 2'd2) state_next = vvbs_pkg::ST_POS;
            vvbs_pkg::ST_POS:
                if (ph_reg && idx_reg == 2'd2) state_next = vvbs_pkg::ST_ACC;
            vvbs_pkg::ST_ACC:
                if (ph_reg && idx_reg == 2'd2) state_next = vvbs_pkg::ST_HALF2;
            vvbs_pkg::ST_HALF2:
                if (ph_reg && idx_reg == 2'd2) state_next = vvbs_pkg::ST_SQSUM;
            vvbs_pkg::ST_SQSUM:
                if (idx_reg == 2'd2) state_next = vvbs_pkg::ST_SQRT;
            vvbs_pkg::ST_SQRT:
                if (cnt_reg == 6'd32) state_next = vvbs_pkg::ST_SQRT_RND;
            vvbs_pkg::ST_SQRT_RND:
                state_next = (cmd_reg == vvbs_pkg::CMD_STEP && root_reg != 34'd0)
                    ? vvbs_pkg::ST_DIV : vvbs_pkg::ST_OUT;
            vvbs_pkg::ST_DIV:
                if (cnt_reg == 6'd50) state_next = vvbs_pkg::ST_DIV_NEXT;
            vvbs_pkg::ST_DIV_NEXT:
                if (idx_reg == 2'd2) state_next = vvbs_pkg::ST_OUT;
                else state_next = vvbs_pkg::ST_DIV;
            vvbs_pkg::ST_OUT:
                state_next = vvbs_pkg::ST_IDLE;
            default:
                state_next = vvbs_pkg::ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vvbs_pkg::ST_IDLE;
            inv_mass_reg  <= vvbs_pkg::INV_MASS_RESET;
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            ph_reg        <= 1'b0;
            cnt_reg       <= 6'd0;
            cmd_reg       <= 2'd0;
            dt_reg        <= 16'd0;
            sq_reg        <= 66'd0;
            rem_reg       <= 66'd0;
            root_reg      <= 34'd0;
            dnum_reg      <= 50'd0;
            drem_reg      <= 50'd0;
            quo_reg       <= 50'd0;
            for (int i = 0; i < 3; i++)
            begin
                vec_reg[i] <= 32'd0;
                pos_reg[i] <= 32'd0;
                vel_reg[i] <= 32'd0;
                acc_reg[i] <= 32'd0;
            end
            fwd_reg[0] <= vvbs_pkg::FWD_ONE;
            fwd_reg[1] <= 18'd0;
            fwd_reg[2] <= 18'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                inv_mass_reg <= cfg_wdata;
            if (m_axis_tvalid && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                vvbs_pkg::ST_IDLE:
                begin
                    idx_reg <= 2'd0;
                    ph_reg  <= 1'b0;
                    sq_reg  <= 66'd0;
                    if (s_axis_tvalid && !busy)
                    begin
                        cmd_reg    <= s_axis_tdata[1:0];
                        dt_reg     <= s_axis_tdata[17:2];
                        vec_reg[0] <= s_axis_tdata[49:18];
                        vec_reg[1] <= s_axis_tdata[81:50];
                        vec_reg[2] <= s_axis_tdata[113:82];
                        if (s_axis_tdata[1:0] == vvbs_pkg::CMD_LOAD_POS)
                        begin
                            pos_reg[0] <= s_axis_tdata[49:18];
                            pos_reg[1] <= s_axis_tdata[81:50];
                            pos_reg[2] <= s_axis_tdata[113:82];
                        end
                        if (s_axis_tdata[1:0] == vvbs_pkg::CMD_LOAD_VEL)
                        begin
                            vel_reg[0] <= s_axis_tdata[49:18];
                            vel_reg[1] <= s_axis_tdata[81:50];
                            vel_reg[2] <= s_axis_tdata[113:82];
                        end
                    end
                end
                vvbs_pkg::ST_HALF1, vvbs_pkg::ST_POS, vvbs_pkg::ST_ACC,
                vvbs_pkg::ST_HALF2:
                begin
                    // Phase one issues the product, phase two writes the result.
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (state_reg == vvbs_pkg::ST_POS)
                            pos_reg[idx_reg] <= mac_res;
                        else if (state_reg == vvbs_pkg::ST_ACC)
                            acc_reg[idx_reg] <= mac_res;
                        else
                            vel_reg[idx_reg] <= mac_res;
                        idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                    end
                end
                vvbs_pkg::ST_SQSUM:
                begin
                    sq_reg  <= sq_reg + 66'($signed(vel_reg[idx_reg]) *
                                          $signed(vel_reg[idx_reg]));
                    idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                    cnt_reg <= 6'd0;
                    rem_reg <= 66'd0;
                    root_reg <= 34'd0;
                end
                vvbs_pkg::ST_SQRT:
                begin
                    // Two radicand bits per cycle from the 64 bit sum, one root bit per cycle.
                    if (cnt_reg != 6'd32)
                    begin
                        sq_reg  <= {sq_reg[63:0], 2'b00};
                        cnt_reg <= cnt_reg + 6'd1;
                        if (sqrt_ok)
                        begin
                            rem_reg  <= sqrt_trial - {30'd0, root_reg, 2'b01};
                            root_reg <= {root_reg[32:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg  <= sqrt_trial;
                            root_reg <= {root_reg[32:0], 1'b0};
                        end
                    end
                end
                vvbs_pkg::ST_SQRT_RND:
                begin
                    if (rem_reg > {32'd0, root_reg})
                        root_reg <= root_reg + 34'd1;
                    idx_reg <= 2'd0;
                    cnt_reg <= 6'd0;
                    drem_reg <= 50'd0;
                end
                vvbs_pkg::ST_DIV:
                begin
                    // Restoring division of (|v|<<16 + L/2) by L, one bit per cycle.
                    if (cnt_reg == 6'd0)
                    begin
                        dnum_reg <= ({2'd0, vabs, 16'd0} + {18'd0, len33[32:1]});
                        drem_reg <= 50'd0;
                        quo_reg  <= 50'd0;
                        cnt_reg  <= 6'd1;
                    end
                    else
                    begin
                        dnum_reg <= {dnum_reg[48:0], 1'b0};
                        if (dsh >= {17'd0, len33})
                        begin
                            drem_reg <= div_trial;
                            quo_reg  <= {quo_reg[48:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= dsh;
                            quo_reg  <= {quo_reg[48:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                vvbs_pkg::ST_DIV_NEXT:
                begin
                    // Clamp to one and restore the sign.
                    logic [17:0] q;
                    q = (quo_reg > 50'd65536) ? 18'd65536 : quo_reg[17:0];
                    fwd_reg[idx_reg] <= vel_reg[idx_reg][31] ? 18'(-q) : q;
                    idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                    cnt_reg <= 6'd0;
                end
                vvbs_pkg::ST_OUT:
                    out_valid_reg <= 1'b1;
                default:
                    idx_reg <= 2'd0;
            endcase
        end
    end

    // Output payload.
    always_comb
    begin
        m_axis_tdata          = '0;
        m_axis_tdata[31:0]    = pos_reg[0];
        m_axis_tdata[63:32]   = pos_reg[1];
        m_axis_tdata[95:64]   = pos_reg[2];
        m_axis_tdata[127:96]  = vel_reg[0];
        m_axis_tdata[159:128] = vel_reg[1];
        m_axis_tdata[191:160] = vel_reg[2];
        m_axis_tdata[222:192] = (root_reg > 34'h7FFF_FFFF) ? 31'h7FFF_FFFF : root_reg[30:0];
        m_axis_tdata[240:223] = fwd_reg[0];
        m_axis_tdata[258:241] = fwd_reg[1];
        m_axis_tdata[276:259] = fwd_reg[2];
    end

endmodule

// File: hdl/vvbs_mac.sv
// Shared multiply, round and accumulate unit: sat(acc + round(a*b >> shift)).
// The product is registered before rounding and the add.
module vvbs_mac
(
    input  logic               clk,
    input  logic signed [31:0] op_a,
    input  logic signed [24:0] op_b,
    input  logic        [4:0]  shift,
    input  logic signed [31:0] acc,
    output logic        [31:0] result
);

    logic signed [56:0] prod_reg;
    logic        [4:0]  shift_reg;
    logic signed [31:0] acc_reg;
    logic signed [65:0] rounded;

    // Register the product and its operands.
    always_ff @(posedge clk)
    begin
        prod_reg  <= op_a * op_b;
        shift_reg <= shift;
        acc_reg   <= acc;
    end

    // Round half up, add and saturate.
    always_comb
    begin
        rounded = (66'(prod_reg) + (66'sd1 <<< (shift_reg - 5'd1))) >>> shift_reg;
        result  = vvbs_pkg::sat32(rounded + 66'(acc_reg));
    end

endmodule
